// ===== rtl/stbs_pkg.sv =====
// Shared widths, defaults and controller/datapath interface types for the sorted-table search.
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 32;

	// controller -> datapath
	typedef struct packed {
		logic write;       // store a load beat into the table
		logic init;        // open the window [0, count) and issue the first read
		logic step;        // narrow the window from the current compare
		logic finish;      // capture a result
		logic report_hit;  // result is a match at the current probe
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;        // probed entry equals the key
		logic exhausted;  // next window is empty
		logic empty;      // live count is zero
	} status_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
// Controller state machine for the sorted-table search.
`timescale 1ns / 1ps

module stbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             kind,
	input  stbs_pkg::status_t st,
	output stbs_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import stbs_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind) begin
						cmd.init = 1'b1;
						// empty table: answer at once
						if (st.empty) begin
							cmd.finish = 1'b1;
						end else begin
							state_d = ST_PROBE;
						end
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_PROBE: begin
				cmd.step = 1'b1;
				if (st.hit) begin
					cmd.finish     = 1'b1;
					cmd.report_hit = 1'b1;
					state_d        = ST_IDLE;
				end else if (st.exhausted) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q == ST_PROBE);
	assign done = done_q;

endmodule

// ===== rtl/stbs_dp.sv =====
// Datapath for the sorted-table search: table memory, count register, window and compare.
`timescale 1ns / 1ps

module stbs_dp #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stbs_pkg::cmd_t                       cmd,
	input  logic        [stbs_pkg::POS_W-1:0]    position,
	input  logic signed [stbs_pkg::VALUE_W-1:0]  value,
	input  logic                                 count_we,
	input  logic        [stbs_pkg::COUNT_W-1:0]  count_wdata,
	output stbs_pkg::status_t                    st,
	output logic                                 found,
	output logic        [stbs_pkg::POS_W-1:0]    match_position
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
	logic signed [VALUE_W-1:0] rdata_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [COUNT_W-1:0]        count_q;
	logic [CW-1:0]             lo_q, hi_q, mid_q;
	logic                      found_q;
	logic [POS_W-1:0]          match_q;

	logic [XW-1:0] count_x;
	logic [CW-1:0] eff_count;
	logic [PW-1:0] pos_x;
	logic          write_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          eq, gt;
	logic [CW-1:0] lo_step, hi_step;
	logic [CW-1:0] lo_n, hi_n, span, mid_n;

	// counts above the depth are clipped to it
	assign count_x   = XW'(count_q);
	assign eff_count = (count_x > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

	// loads past the end of the table are dropped
	assign pos_x    = PW'(position);
	assign write_en = cmd.write && (pos_x < PW'(TABLE_DEPTH));
	assign waddr    = AW'(pos_x);

	assign eq = (rdata_q == key_q);
	assign gt = (rdata_q > key_q);

	// window after the current compare
	always_comb begin
		if (gt) begin
			lo_step = lo_q;
			hi_step = mid_q;
		end else begin
			lo_step = mid_q + CW'(1);
			hi_step = hi_q;
		end
	end

	always_comb begin
		if (cmd.init) begin
			lo_n = '0;
			hi_n = eff_count;
		end else begin
			lo_n = lo_step;
			hi_n = hi_step;
		end
		span  = hi_n - lo_n - CW'(1);
		mid_n = lo_n + (span >> 1);
	end

	assign raddr        = AW'(mid_n);
	assign st.hit       = eq;
	assign st.exhausted = (lo_step >= hi_step);
	assign st.empty     = (eff_count == '0);

	always_ff @(posedge clk) begin
		if (write_en) begin
			mem[waddr] <= value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			key_q <= value;
		end
		if (cmd.init || cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			match_q <= '0;
		end else begin
			if (count_we) begin
				count_q <= count_wdata;
			end
			if (cmd.finish) begin
				found_q <= cmd.report_hit;
				match_q <= cmd.report_hit ? POS_W'(mid_q) : '0;
			end
		end
	end

	assign found          = found_q;
	assign match_position = match_q;

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted-table binary search: controller plus datapath.
`timescale 1ns / 1ps

//  channel   signals                                 accepted when
//  -------   -------------------------------------   -----------------------
//  input     start, busy, kind, position, value     start && !busy at clk
//  result    done, found, match_position            done high (one cycle)
//  config    element_count_we, element_count        element_count_we at clk
//
//  A load beat gives no result. A search beat keeps busy high while it
//  probes the table, at most floor(log2(n))+1 probes for n entries; done
//  comes in the cycle after the last probe, when busy is already low. Each
//  probe is one registered read of the table's read port plus one compare.
//  Reset clears the count and the controller; the table holds nothing
//  defined until loaded. The receiver cannot stall, so each result is shown
//  for exactly one cycle.

module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic        [stbs_pkg::POS_W-1:0]    position,
	input  logic signed [stbs_pkg::VALUE_W-1:0]  value,
	input  logic                                 element_count_we,
	input  logic        [stbs_pkg::COUNT_W-1:0]  element_count,
	output logic                                 done,
	output logic                                 found,
	output logic        [stbs_pkg::POS_W-1:0]    match_position
);
	import stbs_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencing: idle / probing, one probe per cycle
	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// table, window registers, compare and result capture
	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.position       (position),
		.value          (value),
		.count_we       (element_count_we),
		.count_wdata    (element_count),
		.st             (st),
		.found          (found),
		.match_position (match_position)
	);

	// a miss always reports position zero
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> match_position == '0)
		else $error("miss reported with nonzero position");

	// a load beat never produces a result and never starts a search
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind |=> !busy && !done)
		else $error("load beat produced activity");

	// a search only ends through a result strobe
	a_probe_ends_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> busy || done)
		else $error("search ended without result");

	// the strobe only appears once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the sorted-table binary search: directed and random beats.
`timescale 1ns / 1ps

module testbench;
	import stbs_pkg::*;

	localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
	localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
	localparam int STALL_LIMIT   = 2000;   // cycles with no beat and no result
	localparam int SETTLE_CYCLES = 16;     // longer than one full search, plus slack
	localparam int MAX_REPORTS   = 40;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef enum logic {KIND_LOAD = 1'b0, KIND_SEARCH = 1'b1} beat_kind_t;

	// one search outcome
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] where;
	} lookup_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      kind;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;
	logic                      element_count_we;
	logic [COUNT_W-1:0]        element_count;
	logic                      done;
	logic                      found;
	logic [POS_W-1:0]          match_position;

	// Our own copy of the table and the count register. The table is only
	// ever searched over entries that have been loaded: before a search, any
	// unloaded entry on its probe path gets a fill value.
	logic signed [VALUE_W-1:0] table_mirror [DEPTH];
	bit                        loaded [DEPTH];
	logic [COUNT_W-1:0]        count_mirror;
	lookup_t                   lookups_due [$];

	int mismatch_count = 0;
	int beats_sent     = 0;
	int stall_cycles   = 0;
	int gap_pct        = 0;   // chance per cycle that the sender sits idle

	sorted_table_binary_search #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.value(value),
		.element_count_we(element_count_we),
		.element_count(element_count),
		.done(done),
		.found(found),
		.match_position(match_position)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Iterative binary search over [0, count-1], count clamped to the depth.
	// The first probe that matches wins, so duplicates report whichever copy
	// the probe sequence lands on first. Works the same on an unsorted table.
	function automatic lookup_t predict_lookup(logic signed [VALUE_W-1:0] key);
		lookup_t r;
		int lo, hi, mid;
		r  = '0;
		lo = 0;
		hi = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
		while (lo < hi && !r.hit) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (table_mirror[mid] == key) begin
				r.hit   = 1'b1;
				r.where = mid[POS_W-1:0];
			end else if (table_mirror[mid] > key) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	// Ascending fill over the whole signed range, one slot per position.
	function automatic logic signed [VALUE_W-1:0] fill_value(int p);
		longint lv;
		lv = -(longint'(1) << 31) + (longint'(p) << (VALUE_W - POS_W));
		return lv[VALUE_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] entry_or_fill(int p);
		return loaded[p] ? table_mirror[p] : fill_value(p);
	endfunction

	// Drive one beat at the falling edge, after a random idle gap, and hold it
	// until a rising edge sees busy low. Start stays high into the next beat
	// when no gap follows.
	task automatic send_beat(beat_kind_t k, logic [POS_W-1:0] pos,
			logic signed [VALUE_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start    = 1'b1;
		kind     = k;
		position = pos;
		value    = val;
		do @(posedge clk); while (busy);
		if (k == KIND_LOAD) begin
			table_mirror[pos] = val;
			loaded[pos]       = 1'b1;
		end else begin
			lookups_due.push_back(predict_lookup(val));
		end
		beats_sent++;
	endtask

	// Walk the probe path of a key and load every entry on it not yet loaded.
	task automatic load_probe_path(logic signed [VALUE_W-1:0] key);
		int lo, hi, mid;
		bit hit;
		lo  = 0;
		hi  = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
		hit = 1'b0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (!loaded[mid])
				send_beat(KIND_LOAD, mid[POS_W-1:0], fill_value(mid));
			if (table_mirror[mid] == key)
				hit = 1'b1;
			else if (table_mirror[mid] > key)
				hi = mid;
			else
				lo = mid + 1;
		end
	endtask

	task automatic send_search(logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] key);
		load_probe_path(key);
		send_beat(KIND_SEARCH, pos, key);
	endtask

	// Stop sending, let every due result come back, then give a trailing load
	// or search time to retire before anything touches the count.
	task automatic wait_until_quiet();
		@(negedge clk);
		start = 1'b0;
		while (lookups_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_count(int n);
		wait_until_quiet();
		element_count_we = 1'b1;
		element_count    = n[COUNT_W-1:0];
		count_mirror     = n[COUNT_W-1:0];
		@(negedge clk);
		element_count_we = 1'b0;
	endtask

	// Load positions 0..n-1 with ascending values spread over the whole
	// signed range; some steps are zero to make duplicates, and the ends
	// sometimes sit exactly on the most negative / most positive value.
	task automatic load_sorted_run(int n);
		longint step_max, level;
		logic signed [VALUE_W-1:0] v;
		step_max = ((longint'(1) << 32) - 1) / n;
		level = -(longint'(1) << 31);
		if ($urandom_range(3) != 0)
			level += longint'($urandom_range(step_max));
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(7) != 0)
				level += longint'($urandom_range(step_max));
			v = level[VALUE_W-1:0];
			if (i == n - 1 && $urandom_range(3) == 0)
				v = VAL_MAX;
			send_beat(KIND_LOAD, i[POS_W-1:0], v);
		end
	endtask

	// Search for a key that is mostly in the live window, sometimes a near
	// miss, sometimes anything at all, sometimes an extreme.
	task automatic search_random_key();
		int live, pick;
		logic signed [VALUE_W-1:0] key;
		live = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
		pick = $urandom_range(99);
		if (live > 0 && pick < 50)
			key = entry_or_fill($urandom_range(live - 1));
		else if (live > 0 && pick < 70)
			key = entry_or_fill($urandom_range(live - 1)) +
				(($urandom_range(1) == 0) ? 1 : -1);
		else if (pick < 85)
			key = $urandom;
		else
			case ($urandom_range(3))
				0: key = VAL_MIN;
				1: key = VAL_MAX;
				2: key = '0;
				default: key = -1;
			endcase
		send_search(POS_W'($urandom), key);
	endtask

	// Count is zero out of reset: every search misses.
	task automatic test_empty_table();
		send_beat(KIND_SEARCH, '0, VAL_MIN);
		send_beat(KIND_SEARCH, '1, VAL_MAX);
		send_beat(KIND_SEARCH, '0, '0);
	endtask

	// Eight entries with both extremes and a duplicate pair; hits at each end,
	// misses between entries, then a one-entry table and an explicit zero count.
	task automatic test_small_table();
		logic signed [VALUE_W-1:0] ladder [8];
		ladder = '{VAL_MIN, -1000, -1, 0, 0, 5, 77, VAL_MAX};
		for (int i = 0; i < 8; i++)
			send_beat(KIND_LOAD, i[POS_W-1:0], ladder[i]);
		set_count(8);
		send_beat(KIND_SEARCH, '0, VAL_MIN);
		send_beat(KIND_SEARCH, '0, VAL_MAX);
		send_beat(KIND_SEARCH, '0, '0);
		send_beat(KIND_SEARCH, '0, 5);
		send_beat(KIND_SEARCH, '0, -1000);
		send_beat(KIND_SEARCH, '0, 6);
		send_beat(KIND_SEARCH, '0, VAL_MIN + 1);
		set_count(1);
		send_beat(KIND_SEARCH, '0, VAL_MIN);
		send_beat(KIND_SEARCH, '0, VAL_MAX);
		set_count(0);
		send_beat(KIND_SEARCH, '0, VAL_MIN);
	endtask

	// Search a full-depth sorted table, then with the count above the depth,
	// which must behave as the full table. Entries are loaded along each
	// probe path; the last one holds the most positive value, so that key
	// takes the longest path.
	task automatic test_full_table();
		for (int i = 0; i < 8; i++)
			send_beat(KIND_LOAD, i[POS_W-1:0], fill_value(i));
		send_beat(KIND_LOAD, POS_W'(DEPTH - 1), VAL_MAX);
		set_count(DEPTH);
		send_search('0, entry_or_fill(0));
		send_search('1, entry_or_fill(DEPTH - 1));
		send_search('0, entry_or_fill(DEPTH / 2));
		repeat (8) search_random_key();
		set_count(COUNT_MAX);
		send_search('0, entry_or_fill(DEPTH - 1));
		send_search('0, VAL_MAX);
		repeat (8) search_random_key();
	endtask

	// Each round: a fresh short sorted run and its count, then a burst of
	// searches with the odd stray load that may break the ordering. Now and
	// then the count is zero, large, or past the depth over whatever the
	// table already holds; unloaded entries on a probe path are filled first.
	task automatic test_random_traffic(int gap, int beats);
		int stop_at, n, pick;
		gap_pct = gap;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				n = 0;
			end else if (pick < 10) begin
				n = $urandom_range(DEPTH, 65);
			end else if (pick < 13) begin
				n = $urandom_range(COUNT_MAX, DEPTH + 1);
			end else begin
				n = $urandom_range(32, 1);
				load_sorted_run(n);
			end
			set_count(n);
			repeat ($urandom_range(12, 4)) begin
				if ($urandom_range(9) == 0)
					send_beat(KIND_LOAD, POS_W'($urandom), $urandom);
				else
					search_random_key();
			end
		end
	endtask

	// Result checker: done marks a one-cycle result beat, compared against the
	// oldest search still due.
	always @(posedge clk) begin
		lookup_t due;
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with no search due: found=%0b match_position=%0d",
						$time, found, match_position);
			end else begin
				due = lookups_due.pop_front();
				if (found !== due.hit) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: found: expected %0b, actual %0b",
							$time, due.hit, found);
				end
				if (match_position !== due.where) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: match_position: expected %0d, actual %0d",
							$time, due.where, match_position);
				end
			end
		end
	end

	// Watchdog: any beat accepted or result seen restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		kind             = KIND_LOAD;
		position         = '0;
		value            = '0;
		element_count_we = 1'b0;
		element_count    = '0;
		count_mirror     = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_small_table();
		test_full_table();
		test_random_traffic(0, 160);
		test_random_traffic(84, 160);
		test_random_traffic(25, 160);

		wait_until_quiet();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
